// File: rtl/core/assert_macros.svh
// Assertion macros used by sorted_region_map to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/srm_pkg.sv
// Types, codes and controller/datapath interface structs for the region map.
`timescale 1ns / 1ps
`default_nettype none

package srm_pkg;

  // Input item
  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] start_addr;
    logic [63:0] end_addr;
    logic [63:0] low_bound;
    logic [63:0] high_bound;
    logic [63:0] span_length;
    logic [7:0]  access_bits;
    logic [15:0] region_flags_in;
    logic [63:0] file_offset;
  } req_t;

  // Result item
  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [63:0] found_addr;
  } rsp_t;

  // One table entry
  typedef struct packed {
    logic [63:0] start;
    logic [63:0] last;
    logic [7:0]  access;
    logic [15:0] flags;
    logic [63:0] offset;
  } rec_t;

  // Actions
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_FWD    = 3'd2;
  localparam logic [2:0] ACT_BWD    = 3'd3;
  localparam logic [2:0] ACT_FIXED  = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_OVERLAP = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NOSPACE = 3'd4;

  // Datapath micro-operations
  localparam logic [4:0] U_NOP      = 5'd0;
  localparam logic [4:0] U_LOAD     = 5'd1;
  localparam logic [4:0] U_CLEAR    = 5'd2;
  localparam logic [4:0] U_SCAN_INI = 5'd3;
  localparam logic [4:0] U_FX_INI   = 5'd4;
  localparam logic [4:0] U_FW_INI   = 5'd5;
  localparam logic [4:0] U_BW_INI   = 5'd6;
  localparam logic [4:0] U_FIT      = 5'd7;
  localparam logic [4:0] U_IDX_INC  = 5'd8;
  localparam logic [4:0] U_HOLD     = 5'd9;
  localparam logic [4:0] U_FW_ADV   = 5'd10;
  localparam logic [4:0] U_BP_HIT   = 5'd11;
  localparam logic [4:0] U_P_DEC    = 5'd12;
  localparam logic [4:0] U_BL_ADV   = 5'd13;
  localparam logic [4:0] U_OPEN_INS = 5'd14;
  localparam logic [4:0] U_OPEN_SPL = 5'd15;
  localparam logic [4:0] U_OPEN_WR  = 5'd16;
  localparam logic [4:0] U_WR_NEW   = 5'd17;
  localparam logic [4:0] U_WR_HEAD  = 5'd18;
  localparam logic [4:0] U_WR_TAIL  = 5'd19;
  localparam logic [4:0] U_WR_SPHI  = 5'd20;
  localparam logic [4:0] U_WR_SPLO  = 5'd21;
  localparam logic [4:0] U_CLOSE_IN = 5'd22;
  localparam logic [4:0] U_CLOSE_WR = 5'd23;
  localparam logic [4:0] U_CNT_DEC  = 5'd24;
  localparam logic [4:0] U_PUBLISH  = 5'd25;

  // Read address selects
  localparam logic [1:0] RS_IDX = 2'd0;
  localparam logic [1:0] RS_P   = 2'd1;
  localparam logic [1:0] RS_KM1 = 2'd2;
  localparam logic [1:0] RS_KP1 = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic [4:0] uop;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic [2:0] code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] act;
    logic       rng_ok;
    logic       args_bad;
    logic       a_unal;
    logic       fwd_ovf;
    logic       bwd_nofit;
    logic       idx_lt_cnt;
    logic       full;
    logic       p_zero;
    logic       k_gt_lim;
    logic       kp1_lt_cnt;
    logic       fit;
    logic       rd_last_lt_probe;
    logic       rd_start_gt_stop;
    logic       rd_last_all1;
    logic       rd_bw_fail;
    logic       hd_start_le_end;
    logic       hd_start_gt_s;
    logic       hd_eq_start;
    logic       hd_cut_last;
    logic       slot_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/sorted_region_map.sv
// sorted_region_map: sorted table of page-aligned regions with free-span search.
// Input channel (in_valid_i/in_ready_o, in_item_i) takes one request item:
// insert, remove, find forward, find backward, find fixed or clear.
// Output channel (out_valid_o/out_ready_i, out_item_o) returns one result
// item per request: ok, status code and the found address.
// One item is worked at a time. Clear and rejected requests go from
// decode straight to the result; other items scan the table entry by
// entry, move entries on insert, split or unlink, and try one probe
// after another for a search. The controller gives the table memory
// one registered read or one write per cycle.
// A result waits in an output register; a new item is accepted while it
// waits, and the next result is held back until the receiver takes it.
// Reset empties the table (region count zero); entry contents are left as
// they are and are never read before they are written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_region_map #(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned PAGE_SHIFT  = 12
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  srm_pkg::req_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output srm_pkg::rsp_t out_item_o
);
  import srm_pkg::*;

`include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  srm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srm_dp #(
    .MaxRegions (MAX_REGIONS),
    .PageShift  (PAGE_SHIFT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // Checks
  `SRM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "item accepted while busy")
  `SRM_ASSERT_IMPL(a_ok_matches_status, clk_i, rst_ni, out_valid_o, out_item_o.ok == (out_item_o.status == ST_OK), "ok flag disagrees with status")
  `SRM_ASSERT_IMPL(a_found_zero_on_fail, clk_i, rst_ni, out_valid_o && !out_item_o.ok, out_item_o.found_addr == '0, "found address on failure")
  `SRM_ASSERT_IMPL(a_no_insert_when_full, clk_i, rst_ni, cmd.uop == U_WR_NEW || cmd.uop == U_WR_SPLO, !sts.full, "table grows past capacity")

endmodule

`default_nettype wire

// File: rtl/core/srm_dp.sv
// Datapath: region table memory, scan counters, probe arithmetic, result register.
`timescale 1ns / 1ps
`default_nettype none

module srm_dp #(
  parameter int unsigned MaxRegions = 16,
  parameter int unsigned PageShift  = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  srm_pkg::req_t      in_item_i,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output srm_pkg::rsp_t      out_item_o,
  input  srm_pkg::cmd_t      cmd_i,
  output srm_pkg::sts_t      sts_o
);
  import srm_pkg::*;

  localparam int unsigned IW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int unsigned CW = $clog2(MaxRegions + 1);
  localparam logic [63:0] PgMask = 64'((65'd1 << PageShift) - 65'd1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxRegions);
  localparam logic [63:0] AllOnes = '1;

  rec_t          mem_q [MaxRegions];
  rec_t          rdata_q, hold_q, wr_data;
  req_t          req_q;
  rsp_t          out_q;
  logic          out_valid_q;
  logic [CW-1:0] cnt_q, idx_q, k_q, lim_q, p_q;
  logic [63:0]   probe_q, stop_q;
  logic          fit_q;
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [CW-1:0] idx_p1, k_m1, k_p1, p_m1;
  logic [CW:0]   k_p1_w;

  assign idx_p1 = idx_q + CW'(1);
  assign k_m1   = k_q - CW'(1);
  assign k_p1   = k_q + CW'(1);
  assign p_m1   = p_q - CW'(1);
  assign k_p1_w = {1'b0, k_q} + {{CW{1'b0}}, 1'b1};

  // Request checks
  logic [63:0] s, e, lo, hi, len, len_m1, e_p1;
  logic        range_ok, args_bad;
  assign s      = req_q.start_addr;
  assign e      = req_q.end_addr;
  assign lo     = req_q.low_bound;
  assign hi     = req_q.high_bound;
  assign len    = req_q.span_length;
  assign len_m1 = len - 64'd1;
  assign e_p1   = e + 64'd1;
  assign range_ok = (e >= s) && ((s & PgMask) == '0) && ((e_p1 & PgMask) == '0);
  assign args_bad = (len == '0) || (hi < lo) || ((len & PgMask) != '0);

  // Forward search start: hint or low bound, rounded up, raised to low bound
  logic [63:0] fw_p0, fw_rnd, fw_init;
  logic        fw_unal;
  assign fw_p0   = (s == '0) ? lo : s;
  assign fw_unal = (fw_p0 & PgMask) != '0;
  assign fw_rnd  = fw_unal ? ((fw_p0 + PgMask) & ~PgMask) : fw_p0;
  assign fw_init = (fw_rnd < lo) ? lo : fw_rnd;

  // Backward search start: highest aligned start that fits, or the hint rounded down if lower
  logic [63:0] bw_top, bw_p0, bw_init;
  assign bw_top  = (hi - len + 64'd1) & ~PgMask;
  assign bw_p0   = (s == '0) ? bw_top : (s & ~PgMask);
  assign bw_init = (bw_p0 > bw_top) ? bw_top : bw_p0;

  // Span fit of the probe
  logic [64:0] sum65;
  logic        fit_now;
  assign sum65   = {1'b0, probe_q} + {1'b0, len_m1};
  assign fit_now = (probe_q >= lo) && (probe_q <= hi) && !sum65[64] && (sum65[63:0] <= hi);

  // Write port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[IW-1:0];
    wr_data = hold_q;
    case (cmd_i.uop)
      U_OPEN_WR, U_CLOSE_WR: begin
        wr_en   = 1'b1;
        wr_addr = k_q[IW-1:0];
        wr_data = rdata_q;
      end
      U_WR_NEW: begin
        wr_en   = 1'b1;
        wr_data = '{start: s, last: e, access: req_q.access_bits,
                    flags: req_q.region_flags_in, offset: req_q.file_offset};
      end
      U_WR_HEAD: begin
        wr_en         = 1'b1;
        wr_data.start = e_p1;
      end
      U_WR_SPHI: begin
        wr_en         = 1'b1;
        wr_addr       = idx_p1[IW-1:0];
        wr_data.start = e_p1;
      end
      U_WR_TAIL, U_WR_SPLO: begin
        wr_en        = 1'b1;
        wr_data.last = s - 64'd1;
      end
      default: ;
    endcase
  end

  // Read port selection
  always_comb begin
    case (cmd_i.rd_sel)
      RS_P:    rd_addr = p_m1[IW-1:0];
      RS_KM1:  rd_addr = k_m1[IW-1:0];
      RS_KP1:  rd_addr = k_p1[IW-1:0];
      default: rd_addr = idx_q[IW-1:0];
    endcase
  end

  // Table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rdata_q <= mem_q[rd_addr];
  end

  // Region count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.uop)
        U_CLEAR:                       cnt_q <= '0;
        U_WR_NEW, U_WR_SPLO:           cnt_q <= cnt_q + CW'(1);
        U_CNT_DEC:                     cnt_q <= cnt_q - CW'(1);
        default: ;
      endcase
      if (cmd_i.uop == U_PUBLISH) out_valid_q <= 1'b1;
      else if (out_ready_i)       out_valid_q <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.uop)
      U_LOAD:     req_q <= in_item_i;
      U_SCAN_INI: begin
        idx_q   <= '0;
        probe_q <= s;
      end
      U_FX_INI: begin
        idx_q   <= '0;
        probe_q <= s;
      end
      U_FW_INI: begin
        idx_q   <= '0;
        probe_q <= fw_init;
      end
      U_BW_INI: begin
        idx_q   <= '0;
        p_q     <= '0;
        probe_q <= bw_init;
      end
      U_FIT: begin
        stop_q <= sum65[63:0];
        fit_q  <= fit_now;
      end
      U_IDX_INC:  idx_q <= idx_p1;
      U_HOLD:     hold_q <= rdata_q;
      U_FW_ADV: begin
        probe_q <= rdata_q.last + 64'd1;
        idx_q   <= idx_p1;
      end
      U_BP_HIT: begin
        p_q   <= idx_p1;
        idx_q <= idx_p1;
      end
      U_P_DEC:    p_q <= p_m1;
      U_BL_ADV: begin
        probe_q <= (rdata_q.start - len) & ~PgMask;
        p_q     <= p_m1;
      end
      U_OPEN_INS: begin
        k_q   <= cnt_q;
        lim_q <= idx_q;
      end
      U_OPEN_SPL: begin
        k_q   <= cnt_q;
        lim_q <= idx_p1;
      end
      U_OPEN_WR:  k_q <= k_m1;
      U_CLOSE_IN: k_q <= idx_q;
      U_CLOSE_WR: k_q <= k_p1;
      U_PUBLISH: begin
        out_q.ok         <= (cmd_i.code == ST_OK);
        out_q.status     <= cmd_i.code;
        out_q.found_addr <= ((cmd_i.code == ST_OK) &&
                             (req_q.action == ACT_FWD || req_q.action == ACT_BWD ||
                              req_q.action == ACT_FIXED)) ? probe_q : '0;
      end
      default: ;
    endcase
  end

  // Status to the controller
  always_comb begin
    sts_o.act              = req_q.action;
    sts_o.rng_ok           = range_ok;
    sts_o.args_bad         = args_bad;
    sts_o.a_unal           = (s & PgMask) != '0;
    sts_o.fwd_ovf          = fw_unal && (fw_p0 > (AllOnes - PgMask));
    sts_o.bwd_nofit        = len_m1 > (hi - lo);
    sts_o.idx_lt_cnt       = idx_q < cnt_q;
    sts_o.full             = cnt_q >= MaxCnt;
    sts_o.p_zero           = p_q == '0;
    sts_o.k_gt_lim         = k_q > lim_q;
    sts_o.kp1_lt_cnt       = k_p1_w < {1'b0, cnt_q};
    sts_o.fit              = fit_q;
    sts_o.rd_last_lt_probe = rdata_q.last < probe_q;
    sts_o.rd_start_gt_stop = rdata_q.start > stop_q;
    sts_o.rd_last_all1     = rdata_q.last == AllOnes;
    sts_o.rd_bw_fail       = (rdata_q.start <= lo) || (len > (rdata_q.start - lo));
    sts_o.hd_start_le_end  = hold_q.start <= e;
    sts_o.hd_start_gt_s    = hold_q.start > s;
    sts_o.hd_eq_start      = hold_q.start == s;
    sts_o.hd_cut_last      = e >= hold_q.last;
    sts_o.slot_free        = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/core/srm_ctrl.sv
// Controller: sequences table scans, shifts and searches for one item at a time.
`timescale 1ns / 1ps
`default_nettype none

module srm_ctrl (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  srm_pkg::sts_t sts_i,
  output srm_pkg::cmd_t cmd_o
);
  import srm_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DECODE   = 5'd1;
  localparam logic [4:0] S_FIT      = 5'd2;
  localparam logic [4:0] S_FITCHK   = 5'd3;
  localparam logic [4:0] S_FX_RD    = 5'd4;
  localparam logic [4:0] S_FX_EX    = 5'd5;
  localparam logic [4:0] S_FW_RD    = 5'd6;
  localparam logic [4:0] S_FW_EX    = 5'd7;
  localparam logic [4:0] S_BP_RD    = 5'd8;
  localparam logic [4:0] S_BP_EX    = 5'd9;
  localparam logic [4:0] S_BL_RD    = 5'd10;
  localparam logic [4:0] S_BL_EX    = 5'd11;
  localparam logic [4:0] S_SC_RD    = 5'd12;
  localparam logic [4:0] S_SC_EX    = 5'd13;
  localparam logic [4:0] S_POST     = 5'd14;
  localparam logic [4:0] S_OPEN_RD  = 5'd15;
  localparam logic [4:0] S_OPEN_WR  = 5'd16;
  localparam logic [4:0] S_SP_LO    = 5'd17;
  localparam logic [4:0] S_CLOSE_RD = 5'd18;
  localparam logic [4:0] S_CLOSE_WR = 5'd19;
  localparam logic [4:0] S_DONE     = 5'd20;

  logic [4:0] state_q, state_d;
  logic [2:0] code_q, code_d;
  logic       loop_q, loop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
      loop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      loop_q  <= loop_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    loop_d  = loop_q;
    cmd_o   = '{uop: U_NOP, rd_en: 1'b0, rd_sel: RS_IDX, code: ST_OK};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.uop = U_LOAD;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (sts_i.act)
          ACT_INSERT, ACT_REMOVE: begin
            if (!sts_i.rng_ok) code_d = ST_INVALID;
            else begin
              cmd_o.uop = U_SCAN_INI;
              state_d   = S_SC_RD;
            end
          end
          ACT_FIXED: begin
            if (sts_i.args_bad || sts_i.a_unal) code_d = ST_INVALID;
            else begin
              cmd_o.uop = U_FX_INI;
              state_d   = S_FIT;
            end
          end
          ACT_FWD: begin
            if (sts_i.args_bad)     code_d = ST_INVALID;
            else if (sts_i.fwd_ovf) code_d = ST_NOSPACE;
            else begin
              cmd_o.uop = U_FW_INI;
              state_d   = S_FIT;
            end
          end
          ACT_BWD: begin
            if (sts_i.args_bad)       code_d = ST_INVALID;
            else if (sts_i.bwd_nofit) code_d = ST_NOSPACE;
            else begin
              cmd_o.uop = U_BW_INI;
              loop_d    = 1'b0;
              state_d   = S_FIT;
            end
          end
          ACT_CLEAR: begin
            cmd_o.uop = U_CLEAR;
            code_d    = ST_OK;
          end
          default: code_d = ST_INVALID;
        endcase
      end
      S_FIT: begin
        cmd_o.uop = U_FIT;
        state_d   = S_FITCHK;
      end
      S_FITCHK: begin
        if (!sts_i.fit) begin
          code_d  = ST_NOSPACE;
          state_d = S_DONE;
        end else begin
          case (sts_i.act)
            ACT_FIXED: state_d = S_FX_RD;
            ACT_FWD:   state_d = S_FW_RD;
            ACT_BWD: begin
              loop_d  = 1'b1;
              state_d = loop_q ? S_BL_RD : S_BP_RD;
            end
            default: begin
              code_d  = ST_INVALID;
              state_d = S_DONE;
            end
          endcase
        end
      end
      // Fixed address: any region reaching into the span is a clash
      S_FX_RD: begin
        if (!sts_i.idx_lt_cnt) begin
          code_d  = ST_OK;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_FX_EX;
        end
      end
      S_FX_EX: begin
        if (sts_i.rd_start_gt_stop) begin
          code_d  = ST_OK;
          state_d = S_DONE;
        end else if (!sts_i.rd_last_lt_probe) begin
          code_d  = ST_OVERLAP;
          state_d = S_DONE;
        end else begin
          cmd_o.uop = U_IDX_INC;
          state_d   = S_FX_RD;
        end
      end
      // Forward: hop past each blocking region
      S_FW_RD: begin
        if (!sts_i.idx_lt_cnt) begin
          code_d  = ST_OK;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_FW_EX;
        end
      end
      S_FW_EX: begin
        if (sts_i.rd_last_lt_probe) begin
          cmd_o.uop = U_IDX_INC;
          state_d   = S_FW_RD;
        end else if (sts_i.rd_start_gt_stop) begin
          code_d  = ST_OK;
          state_d = S_DONE;
        end else if (sts_i.rd_last_all1) begin
          code_d  = ST_NOSPACE;
          state_d = S_DONE;
        end else begin
          cmd_o.uop = U_FW_ADV;
          state_d   = S_FIT;
        end
      end
      // Backward: find last region starting at or below the span end
      S_BP_RD: begin
        if (!sts_i.idx_lt_cnt) state_d = S_BL_RD;
        else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_BP_EX;
        end
      end
      S_BP_EX: begin
        if (!sts_i.rd_start_gt_stop) begin
          cmd_o.uop = U_BP_HIT;
          state_d   = S_BP_RD;
        end else state_d = S_BL_RD;
      end
      // Backward: step below each blocking region
      S_BL_RD: begin
        if (sts_i.p_zero) begin
          code_d  = ST_OK;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RS_P;
          state_d      = S_BL_EX;
        end
      end
      S_BL_EX: begin
        if (sts_i.rd_start_gt_stop) begin
          cmd_o.uop = U_P_DEC;
          state_d   = S_BL_RD;
        end else if (sts_i.rd_last_lt_probe) begin
          code_d  = ST_OK;
          state_d = S_DONE;
        end else if (sts_i.rd_bw_fail) begin
          code_d  = ST_NOSPACE;
          state_d = S_DONE;
        end else begin
          cmd_o.uop = U_BL_ADV;
          state_d   = S_FIT;
        end
      end
      // Insert/remove: first region ending at or after the start
      S_SC_RD: begin
        if (!sts_i.idx_lt_cnt) state_d = S_POST;
        else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SC_EX;
        end
      end
      S_SC_EX: begin
        if (sts_i.rd_last_lt_probe) begin
          cmd_o.uop = U_IDX_INC;
          state_d   = S_SC_RD;
        end else begin
          cmd_o.uop = U_HOLD;
          state_d   = S_POST;
        end
      end
      S_POST: begin
        state_d = S_DONE;
        code_d  = ST_OK;
        if (sts_i.act == ACT_INSERT) begin
          if (sts_i.idx_lt_cnt && sts_i.hd_start_le_end) code_d = ST_OVERLAP;
          else if (sts_i.full) code_d = ST_FULL;
          else begin
            cmd_o.uop = U_OPEN_INS;
            state_d   = S_OPEN_RD;
          end
        end else begin
          if (!sts_i.idx_lt_cnt || sts_i.hd_start_gt_s) code_d = ST_OK;
          else if (sts_i.hd_eq_start && sts_i.hd_cut_last) begin
            cmd_o.uop = U_CLOSE_IN;
            state_d   = S_CLOSE_RD;
          end else if (sts_i.hd_eq_start) cmd_o.uop = U_WR_HEAD;
          else if (sts_i.hd_cut_last)     cmd_o.uop = U_WR_TAIL;
          else if (sts_i.full)            code_d = ST_FULL;
          else begin
            cmd_o.uop = U_OPEN_SPL;
            state_d   = S_OPEN_RD;
          end
        end
      end
      // Open a slot by moving entries up one place
      S_OPEN_RD: begin
        if (sts_i.k_gt_lim) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RS_KM1;
          state_d      = S_OPEN_WR;
        end else if (sts_i.act == ACT_INSERT) begin
          cmd_o.uop = U_WR_NEW;
          code_d    = ST_OK;
          state_d   = S_DONE;
        end else begin
          cmd_o.uop = U_WR_SPHI;
          state_d   = S_SP_LO;
        end
      end
      S_OPEN_WR: begin
        cmd_o.uop = U_OPEN_WR;
        state_d   = S_OPEN_RD;
      end
      S_SP_LO: begin
        cmd_o.uop = U_WR_SPLO;
        code_d    = ST_OK;
        state_d   = S_DONE;
      end
      // Close a slot by moving entries down one place
      S_CLOSE_RD: begin
        if (sts_i.kp1_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RS_KP1;
          state_d      = S_CLOSE_WR;
        end else begin
          cmd_o.uop = U_CNT_DEC;
          code_d    = ST_OK;
          state_d   = S_DONE;
        end
      end
      S_CLOSE_WR: begin
        cmd_o.uop = U_CLOSE_WR;
        state_d   = S_CLOSE_RD;
      end
      S_DONE: begin
        if (sts_i.slot_free) begin
          cmd_o.uop  = U_PUBLISH;
          cmd_o.code = code_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire
